// ===== design/ecig_pkg.sv =====
package ecig_pkg;

    // Width of a decoded run length: nine decimal digits fit in 30 bits.
    localparam int VAL_W = 30;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_OP     = 3'd1;
    localparam logic [2:0] ERR_PAST_SEQ   = 3'd2;
    localparam logic [2:0] ERR_BAD_COUNT  = 3'd3;
    localparam logic [2:0] ERR_STORE_FULL = 3'd4;

    localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
    localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_CASE   = 8'h20;  // distance lower to upper case

    localparam logic [7:0] OP_M = 8'h4D;
    localparam logic [7:0] OP_X = 8'h58;
    localparam logic [7:0] OP_I = 8'h49;
    localparam logic [7:0] OP_D = 8'h44;
    localparam logic [7:0] OP_N = 8'h4E;
    localparam logic [7:0] OP_S = 8'h53;
    localparam logic [7:0] OP_H = 8'h48;
    localparam logic [7:0] OP_P = 8'h50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_PREFIX,
        ST_DIGIT,
        ST_TOKEN,
        ST_X_FETCH,
        ST_X_EMIT
    } state_t;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic [3:0] digit;
    } digit_ctrl_t;

    function automatic logic [7:0] token_of(input logic [7:0] c);
        logic [7:0] tok;
        case (c)
            OP_M, CH_EQ, OP_X: tok = CH_EQ;
            OP_I:              tok = CH_PLUS;
            OP_D:              tok = CH_MINUS;
            OP_N:              tok = CH_STAR;
            OP_S:              tok = CH_RPAREN;
            OP_H, OP_P:        tok = CH_RBRACK;
            default:           tok = 8'h00;
        endcase
        return tok;
    endfunction

    function automatic logic advances(input logic [7:0] c);
        return (c == OP_M) || (c == CH_EQ) || (c == OP_X) || (c == OP_I) || (c == OP_S);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? 8'(c - CH_CASE) : c;
    endfunction

endpackage

// ===== design/ecig_base_mem.sv =====
module ecig_base_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ecig_digits.sv =====
module ecig_digits #(
    parameter int MAX_DIGITS = 9,
    parameter int CNT_W      = $clog2(MAX_DIGITS + 2),
    parameter int IDX_W      = $clog2(MAX_DIGITS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ecig_pkg::digit_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]        rd_idx,
    output logic [CNT_W-1:0]        count,
    output logic [ecig_pkg::VAL_W-1:0] value,
    output logic [3:0]              rd_digit
);
    import ecig_pkg::*;

    logic [3:0]       digit_buf_reg [MAX_DIGITS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             room;

    // One more digit fits in the buffer.
    assign room = count_reg < CNT_W'(MAX_DIGITS);

    always_comb
    begin
        count_next = count_reg;
        value_next = value_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            value_next = '0;
        end
        else if (ctrl.push)
        begin
            if (room)
            begin
                // value * 10 + digit, as two shifts and two adds
                value_next = {value_reg[VAL_W-4:0], 3'b000}
                           + {value_reg[VAL_W-2:0], 1'b0}
                           + VAL_W'(ctrl.digit);
            end
            // saturate one past the limit to flag an overlong count
            if (count_reg <= CNT_W'(MAX_DIGITS))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            value_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear && room)
        begin
            digit_buf_reg[count_reg[IDX_W-1:0]] <= ctrl.digit;
        end
    end

    assign count    = count_reg;
    assign value    = value_reg;
    assign rd_digit = digit_buf_reg[rd_idx];

endmodule

// ===== design/cigar_to_ecigar_converter.sv =====
// Timing: loads and digits are taken while idle; an operation is accepted, then gives
//   one result per cycle while the output is not stalled (prefix, digits, token, or one error
//   result); an X run reads each base from the base store, then emits it (fetch, then emit).
// Throughput: one item per cycle for loads and digits while idle; no new item is taken until
//   the last result of an item is registered; the output register holds a result under backpressure.
// Reset: rst_n clears control, counts, position and output valid; the stores start undefined.
module cigar_to_ecigar_converter #(
    parameter int SEQ_DEPTH  = 64,
    parameter int MAX_DIGITS = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] req_type
    input  logic       s_axis_tlast,   // record_last
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [3:0] m_axis_tuser,   // [2:0] err_code, [3] record_end
    output logic       m_axis_tlast    // last_of_run
);
    import ecig_pkg::*;

    localparam int AW    = $clog2(SEQ_DEPTH);
    localparam int CNT_W = $clog2(MAX_DIGITS + 2);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // Controller and per-read state
    state_t           state_reg,      state_next;
    logic [AW-1:0]    base_count_reg, base_count_next;
    logic [31:0]      pos_reg,        pos_next;
    logic             failed_reg,     failed_next;

    // Latched operation being expanded
    logic [7:0]       op_reg,         op_next;
    logic [2:0]       err_reg,        err_next;
    logic             last_reg,       last_next;
    logic [CNT_W-1:0] emit_len_reg,   emit_len_next;
    logic [IDX_W-1:0] emit_idx_reg,   emit_idx_next;
    logic [AW-1:0]    x_pos_reg,      x_pos_next;
    logic [AW-1:0]    x_end_reg,      x_end_next;

    // Output register
    logic             out_valid_reg,  out_valid_next;
    logic [7:0]       out_char_reg,   out_char_next;
    logic [2:0]       out_err_reg,    out_err_next;
    logic             out_last_reg,   out_last_next;
    logic             out_rec_reg,    out_rec_next;

    // Base store port
    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [7:0]       mem_rd_data;

    // Digit buffer
    digit_ctrl_t      dig_ctrl;
    logic [CNT_W-1:0] dig_count;
    logic [VAL_W-1:0] dig_value;
    logic [3:0]       dig_rd;

    // Item decode
    logic             accept;
    logic             slot_free;
    logic             is_load;
    logic             is_digit;
    logic             is_x;
    logic             op_item;
    logic             store_full;
    logic             count_ok;
    logic [7:0]       in_tok;
    logic [32:0]      run_end;
    logic [2:0]       item_err;
    logic             idx_last;
    logic             x_last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // the output register can take a new result this cycle
    assign slot_free     = !out_valid_reg || m_axis_tready;

    ecig_base_mem #(
        .DEPTH (SEQ_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (base_count_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (mem_rd_en),
        .rd_addr (x_pos_reg),
        .rd_data (mem_rd_data)
    );

    ecig_digits #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_digits (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dig_ctrl),
        .rd_idx   (emit_idx_reg),
        .count    (dig_count),
        .value    (dig_value),
        .rd_digit (dig_rd)
    );

    // Classify the item on the input side and pick its error code, if any.
    always_comb
    begin
        is_load    = !s_axis_tuser;
        is_digit   = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
        is_x       = (s_axis_tdata == OP_X);
        in_tok     = token_of(s_axis_tdata);
        op_item    = !is_load && !failed_reg && !is_digit;
        store_full = (base_count_reg == AW'(SEQ_DEPTH - 1));
        count_ok   = (dig_count != '0) && (dig_count <= CNT_W'(MAX_DIGITS));
        run_end    = {1'b0, pos_reg} + 33'(dig_value);
        item_err   = ERR_NONE;
        if (is_load)
        begin
            if (store_full)
            begin
                item_err = ERR_STORE_FULL;
            end
        end
        else if (op_item)
        begin
            // operation check first, then count, then the end of the sequence for X
            if (!is_x && (in_tok == 8'h00))
            begin
                item_err = ERR_BAD_OP;
            end
            else if (!count_ok)
            begin
                item_err = ERR_BAD_COUNT;
            end
            else if (is_x && (run_end > 33'(base_count_reg)))
            begin
                item_err = ERR_PAST_SEQ;
            end
        end
        idx_last = (CNT_W'(emit_idx_reg) == emit_len_reg - CNT_W'(1));
        x_last   = ((x_pos_reg + AW'(1)) == x_end_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_err != ERR_NONE)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (op_item && is_x)
                    begin
                        // a zero-length X run gives nothing
                        if (dig_value != '0)
                        begin
                            state_next = ST_X_FETCH;
                        end
                    end
                    else if (op_item)
                    begin
                        if ((s_axis_tdata == OP_S) || (s_axis_tdata == OP_H))
                        begin
                            state_next = ST_PREFIX;
                        end
                        else
                        begin
                            state_next = ST_DIGIT;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREFIX:
            begin
                if (slot_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free && idx_last)
                begin
                    state_next = ST_TOKEN;
                end
            end
            ST_TOKEN:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_X_FETCH:
            begin
                state_next = ST_X_EMIT;
            end
            ST_X_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = x_last ? ST_IDLE : ST_X_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        base_count_next = base_count_reg;
        pos_next        = pos_reg;
        failed_next     = failed_reg;
        op_next         = op_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        emit_len_next   = emit_len_reg;
        emit_idx_next   = emit_idx_reg;
        x_pos_next      = x_pos_reg;
        x_end_next      = x_end_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_char_next   = out_char_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        out_rec_next    = out_rec_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        dig_ctrl.push   = 1'b0;
        dig_ctrl.clear  = 1'b0;
        dig_ctrl.digit  = s_axis_tdata[3:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // latch what the expansion needs; all per-read state moves now
                    op_next       = s_axis_tdata;
                    err_next      = item_err;
                    last_next     = !is_load && s_axis_tlast;
                    emit_len_next = dig_count;
                    emit_idx_next = '0;
                    x_pos_next    = pos_reg[AW-1:0];
                    x_end_next    = run_end[AW-1:0];
                    if (item_err != ERR_NONE)
                    begin
                        failed_next = 1'b1;
                    end
                    if (is_load && !store_full)
                    begin
                        mem_wr_en       = 1'b1;
                        base_count_next = base_count_reg + AW'(1);
                    end
                    if (!is_load && !failed_reg && is_digit)
                    begin
                        dig_ctrl.push = 1'b1;
                    end
                    if (op_item)
                    begin
                        dig_ctrl.clear = 1'b1;
                        if (item_err == ERR_NONE)
                        begin
                            if (is_x)
                            begin
                                pos_next = run_end[31:0];
                            end
                            else if (advances(s_axis_tdata))
                            begin
                                // saturate the position
                                pos_next = run_end[32] ? 32'hFFFF_FFFF : run_end[31:0];
                            end
                        end
                    end
                    if (!is_load && s_axis_tlast)
                    begin
                        // end of read: drop trailing digits and start clean
                        base_count_next = '0;
                        pos_next        = '0;
                        failed_next     = 1'b0;
                        dig_ctrl.clear  = 1'b1;
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = 8'h00;
                    out_err_next   = err_reg;
                    out_last_next  = 1'b1;
                    out_rec_next   = last_reg;
                end
            end
            ST_PREFIX:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = (op_reg == OP_S) ? CH_LPAREN : CH_LBRACK;
                    out_err_next   = ERR_NONE;
                    out_last_next  = 1'b0;
                    out_rec_next   = 1'b0;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_ZERO + {4'b0000, dig_rd};
                    out_err_next   = ERR_NONE;
                    out_last_next  = 1'b0;
                    out_rec_next   = 1'b0;
                    emit_idx_next  = emit_idx_reg + IDX_W'(1);
                end
            end
            ST_TOKEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = token_of(op_reg);
                    out_err_next   = ERR_NONE;
                    out_last_next  = 1'b1;
                    out_rec_next   = last_reg;
                end
            end
            ST_X_FETCH:
            begin
                mem_rd_en = 1'b1;
            end
            ST_X_EMIT:
            begin
                // read data for x_pos_reg is ready; the address is held until it is used
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = to_upper(mem_rd_data);
                    out_err_next   = ERR_NONE;
                    out_last_next  = x_last;
                    out_rec_next   = x_last && last_reg;
                    x_pos_next     = x_pos_reg + AW'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_count_reg <= '0;
            pos_reg        <= '0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_count_reg <= base_count_next;
            pos_reg        <= pos_next;
            failed_reg     <= failed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
        emit_len_reg <= emit_len_next;
        emit_idx_reg <= emit_idx_next;
        x_pos_reg    <= x_pos_next;
        x_end_reg    <= x_end_next;
        out_char_reg <= out_char_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
        out_rec_reg  <= out_rec_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = {out_rec_reg, out_err_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== design/ecig_checker.sv =====
module ecig_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import ecig_pkg::*;

    // nothing leaves the block while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the end of a read is always the last result of its item
    a_rec_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast)
        else $error("record end without last of run");

    // an error result carries no character and closes the item's results
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != ERR_NONE)
            |-> (m_axis_tdata == 8'h00) && m_axis_tlast)
        else $error("malformed error result");

    // the block takes no item while it still expands an earlier one into results
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a run");

endmodule

bind cigar_to_ecigar_converter ecig_checker u_ecig_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ecig_pkg::*;

    localparam int SEQ_DEPTH    = 64;
    localparam int MAX_DIGITS   = 9;
    localparam int RANDOM_ITEMS = 380;
    // Worst case is far below this: every item giving a full X run with stalls on both sides.
    localparam int unsigned LIMIT_CYCLES = 400000;
    // Extra time to watch for stray results after all predicted results have arrived.
    localparam int DRAIN_CYCLES = 200;

    // Shapes of generated reads; the first three random reads force the rare corners.
    typedef enum int {
        READ_PLAIN,
        READ_LONG_X,
        READ_OVERFILL,
        READ_SATURATE
    } read_shape_t;

    // One extended CIGAR result as seen on the master side.
    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] err;
        logic       run_end;
        logic       rec_end;
    } ecigar_token_t;

    // Tracks the converter state and holds the results still owed by the block.
    class ecigar_checker;
        bit [7:0]      bases [SEQ_DEPTH];
        bit [3:0]      digits [MAX_DIGITS];
        int unsigned   n_bases;
        int unsigned   n_digits;
        bit [31:0]     read_pos;
        bit            read_bad;
        ecigar_token_t run_out [$];
        ecigar_token_t ecigar_due [$];
        int unsigned   mismatches;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void emit(bit [7:0] ch, bit [2:0] err);
            ecigar_token_t t;
            t.ch      = ch;
            t.err     = err;
            t.run_end = 1'b0;
            t.rec_end = 1'b0;
            run_out.push_back(t);
        endfunction

        function void fail_read(bit [2:0] err);
            emit(8'h00, err);
            read_bad = 1'b1;
        endfunction

        function bit [7:0] symbol_for(bit [7:0] op);
            bit [7:0] sym;
            case (op)
                OP_M, CH_EQ, OP_X: sym = CH_EQ;
                OP_I:              sym = CH_PLUS;
                OP_D:              sym = CH_MINUS;
                OP_N:              sym = CH_STAR;
                OP_S:              sym = CH_RPAREN;
                OP_H, OP_P:        sym = CH_RBRACK;
                default:           sym = 8'h00;
            endcase
            return sym;
        endfunction

        function void predict_op(bit [7:0] op);
            bit [7:0]          sym;
            bit [7:0]          b;
            longint unsigned   run_len;
            longint unsigned   stop;
            longint unsigned   p;
            int unsigned       i;
            sym = symbol_for(op);
            // Bad operation wins over a bad count.
            if (op != OP_X && sym == 8'h00) begin
                fail_read(ERR_BAD_OP);
                return;
            end
            if (n_digits == 0 || n_digits > MAX_DIGITS) begin
                fail_read(ERR_BAD_COUNT);
                return;
            end
            run_len = 0;
            for (i = 0; i < n_digits; i++)
                run_len = run_len * 10 + digits[i];
            if (op == OP_X) begin
                stop = read_pos + run_len;
                if (stop > n_bases) begin
                    fail_read(ERR_PAST_SEQ);
                    return;
                end
                // Spell out the covered bases in upper case.
                for (p = read_pos; p < stop; p++) begin
                    b = bases[p];
                    if (b >= CH_LOW_A && b <= CH_LOW_Z)
                        b = b - CH_CASE;
                    emit(b, ERR_NONE);
                end
                read_pos = stop[31:0];
                return;
            end
            if (op == OP_S)
                emit(CH_LPAREN, ERR_NONE);
            else if (op == OP_H)
                emit(CH_LBRACK, ERR_NONE);
            for (i = 0; i < n_digits; i++)
                emit(CH_ZERO + digits[i], ERR_NONE);
            emit(sym, ERR_NONE);
            if (op == OP_M || op == CH_EQ || op == OP_I || op == OP_S) begin
                stop = read_pos + run_len;
                read_pos = (stop > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stop[31:0];
            end
        endfunction

        function void note_input(bit is_cigar, bit [7:0] ch, bit last);
            run_out.delete();
            if (!is_cigar) begin
                if (n_bases >= SEQ_DEPTH - 1)
                    fail_read(ERR_STORE_FULL);
                else begin
                    bases[n_bases] = ch;
                    n_bases++;
                end
            end else begin
                if (!read_bad) begin
                    if (ch >= CH_ZERO && ch <= CH_NINE) begin
                        if (n_digits < MAX_DIGITS)
                            digits[n_digits] = 4'(ch - CH_ZERO);
                        if (n_digits <= MAX_DIGITS)
                            n_digits++;
                    end else begin
                        predict_op(ch);
                        n_digits = 0;
                    end
                end
                if (last) begin
                    n_bases  = 0;
                    read_pos = 0;
                    n_digits = 0;
                    read_bad = 1'b0;
                    if (run_out.size() > 0)
                        run_out[run_out.size() - 1].rec_end = 1'b1;
                end
            end
            if (run_out.size() > 0)
                run_out[run_out.size() - 1].run_end = 1'b1;
            foreach (run_out[i])
                ecigar_due.push_back(run_out[i]);
        endfunction

        function void check_result(ecigar_token_t got);
            ecigar_token_t want;
            if (ecigar_due.size() == 0) begin
                flag($sformatf("unexpected result out_char %h err %0d last %b record_end %b",
                               got.ch, got.err, got.run_end, got.rec_end));
                return;
            end
            want = ecigar_due.pop_front();
            if (got.ch !== want.ch || got.err !== want.err ||
                got.run_end !== want.run_end || got.rec_end !== want.rec_end)
                flag($sformatf({"expected out_char %h err %0d last %b record_end %b, ",
                                "got out_char %h err %0d last %b record_end %b"},
                               want.ch, want.err, want.run_end, want.rec_end,
                               got.ch, got.err, got.run_end, got.rec_end));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tuser = 1'b0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic       m_axis_tlast;

    int unsigned   cycle_count = 0;
    int unsigned   items_sent = 0;
    ecigar_checker ledger;

    cigar_to_ecigar_converter #(
        .SEQ_DEPTH  (SEQ_DEPTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("cigar_to_ecigar_converter verification failed");
            $finish;
        end
    end

    // Recurring windows where neither side idles, so back-to-back transfers get exercised.
    function automatic bit quiet_window();
        return (cycle_count % 4500) >= 1500 && (cycle_count % 4500) < 2700;
    endfunction

    function automatic bit source_rests();
        return !quiet_window() && ($urandom_range(99) < 26);
    endfunction

    // Sink: stall about a quarter of the cycles outside the quiet windows.
    always @(posedge clk)
        m_axis_tready <= quiet_window() || ($urandom_range(99) >= 26);

    // Check every result transfer against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_result({m_axis_tdata, m_axis_tuser[2:0], m_axis_tlast,
                                 m_axis_tuser[3]});
    end

    function automatic bit [7:0] pick_base();
        string letters;
        int    k;
        letters = "acgtnACGTN";
        k = $urandom_range(11);
        if (k < 10)
            return letters[k];
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [7:0] op_at(int k);
        case (k)
            0:       return OP_M;
            1:       return CH_EQ;
            2:       return OP_X;
            3:       return OP_I;
            4:       return OP_D;
            5:       return OP_N;
            6:       return OP_S;
            7:       return OP_H;
            default: return OP_P;
        endcase
    endfunction

    function automatic bit moves_pos(bit [7:0] op);
        return op == OP_M || op == CH_EQ || op == OP_X || op == OP_I || op == OP_S;
    endfunction

    // Any byte that is neither a digit nor a CIGAR operation.
    function automatic bit [7:0] junk_char();
        bit [7:0] c;
        bit       taken;
        taken = 1'b1;
        while (taken)
        begin
            c = 8'($urandom_range(255));
            taken = (c >= CH_ZERO && c <= CH_NINE);
            for (int k = 0; k < 9; k++)
                if (c == op_at(k))
                    taken = 1'b1;
        end
        return c;
    endfunction

    // Present one item; hold it until the block takes it, then record the transfer.
    task automatic send_item(input bit is_cigar, input bit [7:0] ch, input bit last);
        while (source_rests())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_cigar;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ledger.note_input(is_cigar, ch, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b1, s[i], last && (i == s.len() - 1));
    endtask

    // Send a decimal count followed by its operation.
    task automatic send_op(input longint unsigned len, input bit [7:0] op, input bit last);
        string s;
        s = $sformatf("%0d", len);
        send_text(s, 1'b0);
        send_item(1'b1, op, last);
    endtask

    // Well-formed operation; keep X runs inside the loaded bases.
    task automatic random_op(input int nb, ref int pos, input bit last);
        bit [7:0] op;
        int       room;
        int       len;
        op = op_at($urandom_range(8));
        room = (nb > pos) ? nb - pos : 0;
        if (op == OP_X)
            len = $urandom_range(room);
        else if (moves_pos(op))
            len = ($urandom_range(9) == 0) ? $urandom_range(999999999) : $urandom_range(room);
        else
            len = ($urandom_range(9) == 0) ? $urandom_range(999999999) : $urandom_range(40);
        send_op(len, op, last);
        if (moves_pos(op))
            pos = (pos + len > 100000) ? 100000 : pos + len;
    endtask

    // Broken input: bad characters, missing or overlong counts, overruns, stray loads.
    task automatic noise_op(inout int nb, input int pos);
        int room;
        room = (nb > pos) ? nb - pos : 0;
        case ($urandom_range(4))
            0:
            begin
                repeat ($urandom_range(2))
                    send_item(1'b1, 8'(CH_ZERO + $urandom_range(9)), 1'b0);
                send_item(1'b1, junk_char(), 1'b0);
            end
            1: send_item(1'b1, op_at($urandom_range(8)), 1'b0);
            2:
            begin
                repeat (MAX_DIGITS + 1 + $urandom_range(2))
                    send_item(1'b1, 8'(CH_ZERO + $urandom_range(9)), 1'b0);
                send_item(1'b1, op_at($urandom_range(8)), 1'b0);
            end
            3: send_op(room + 1 + $urandom_range(4), OP_X, 1'b0);
            default:
            begin
                send_item(1'b0, pick_base(), 1'($urandom_range(1)));
                if (nb < SEQ_DEPTH - 1)
                    nb++;
            end
        endcase
    endtask

    // One read: load bases, then stream its CIGAR and close it with record_last.
    task automatic random_read(input read_shape_t shape);
        int nb;
        int pos;
        if (shape == READ_LONG_X || shape == READ_OVERFILL)
            nb = SEQ_DEPTH - 1;
        else if ($urandom_range(3) == 0)
            nb = $urandom_range(SEQ_DEPTH - 1);
        else
            nb = $urandom_range(12);
        repeat (nb)
            send_item(1'b0, pick_base(), 1'($urandom_range(1)));
        pos = 0;
        case (shape)
            READ_LONG_X: send_op(nb, OP_X, 1'b1);
            READ_OVERFILL:
            begin
                // Loads into a full store fail the read; the CIGAR that follows is dropped.
                repeat (2)
                    send_item(1'b0, pick_base(), 1'b0);
                random_op(nb, pos, 1'b1);
            end
            READ_SATURATE:
            begin
                // Sum to exactly 2^32: a wrapping position would land on zero.
                repeat (4)
                    send_op(64'd999999999, OP_M, 1'b0);
                send_op(64'd294967300, OP_M, 1'b0);
                send_op(0, OP_X, 1'b1);
            end
            default:
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(99) < 82)
                        random_op(nb, pos, 1'b0);
                    else
                        noise_op(nb, pos);
                end
                case ($urandom_range(9))
                    0:
                    begin
                        // Trailing digits: dropped, no record end.
                        repeat ($urandom_range(1, 3))
                            send_item(1'b1, 8'(CH_ZERO + $urandom_range(9)), 1'b0);
                        send_item(1'b1, 8'(CH_ZERO + $urandom_range(9)), 1'b1);
                    end
                    1: send_item(1'b1, junk_char(), 1'b1);
                    2: send_item(1'b1, op_at($urandom_range(8)), 1'b1);
                    default: random_op(nb, pos, 1'b1);
                endcase
            end
        endcase
    endtask

    initial
    begin
        int unsigned directed_items;
        int          read_idx;
        // drive reset low from time zero so the asynchronous reset takes effect at once
        rst_n <= 1'b0;
        ledger = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operation, prefixes, a zero-length X, then bad-operation, bad-count and past-sequence errors.
        send_item(1'b0, "a", 1'b0);
        send_item(1'b0, "c", 1'b1);
        send_item(1'b0, "g", 1'b0);
        send_item(1'b0, 8'hFF, 1'b0);
        send_text("1S2X0X1I5D3N2H1P4=", 1'b0);
        send_text("9M", 1'b1);
        send_text("Q", 1'b1);
        send_text("M", 1'b1);
        send_text("2X", 1'b1);

        // Random reads, mostly well-formed with random content.
        directed_items = items_sent;
        read_idx = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            case (read_idx)
                0:       random_read(READ_LONG_X);
                1:       random_read(READ_OVERFILL);
                2:       random_read(READ_SATURATE);
                default: random_read(READ_PLAIN);
            endcase
            read_idx++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (ledger.ecigar_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (ledger.ecigar_due.size() != 0)
            ledger.flag($sformatf("%0d results never arrived", ledger.ecigar_due.size()));
        if (ledger.mismatches == 0)
            $display("cigar_to_ecigar_converter verification clean");
        else
            $display("cigar_to_ecigar_converter verification failed");
        $finish;
    end

endmodule
